// File: src/fra_pkg.sv
`default_nettype none

package fra_pkg;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // region size after reset
    localparam logic [31:0] RESET_REGION = 32'd65536;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_FETCH,
        S_A_CHECK,
        S_F_FETCH,
        S_F_CHECK,
        S_F_NX,
        S_F_MERGE,
        S_SCAN,
        S_INS_A,
        S_INS_B,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_START,
        CMD_A_FETCH,
        CMD_A_CHECK,
        CMD_F_FETCH,
        CMD_F_CHECK,
        CMD_F_NX,
        CMD_F_MERGE,
        CMD_SCAN,
        CMD_INS_A,
        CMD_INS_B,
        CMD_DONE
    } cmd_t;

    typedef struct packed {
        logic walk_end;
        logic a_hit;
        logic f_append;
        logic f_before;
        logic scan_found;
        logic scan_none;
        logic ins_two;
        logic clr_last;
        logic out_free;
        logic zero_free;
        logic is_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/free_range_allocator.sv
`default_nettype none

// first-fit range allocator with coalescing: keeps an address-ordered list of
// free ranges over a region of cfg_wdata units (65536 after reset). an allocate
// item takes the first range that fits, shrinking it from the front or removing
// it on an exact fit; a free item is inserted in order and merged with the
// ranges it touches. each item gives one result with status, offset and the
// running free total. an item walks the list one range at a time through the
// single read port of the range table, and a free that is not appended to the
// range before it then scans the used flags one per cycle and writes the table
// in the update steps INS_A and, where needed, INS_B. one item is in work at a
// time; the result sits in an output register so the next item can be taken
// while it waits. after reset and after each write of the region size a
// clearing pass over all ENTRIES used flags runs before in_ready rises.
module free_range_allocator #(
    parameter int ENTRIES     = 64,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request item channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [31:0] request_size,
    input  wire logic [31:0] request_offset,
    // result item channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      granted_offset,
    output logic [31:0]      free_total,
    // region size register
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    fra_pkg::cmd_t     cmd;
    fra_pkg::dp_stat_t stat;

    // sequencer: walk, scan and update steps
    fra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cfg_we   (cfg_we),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    // range table, used flags, compare and merge arithmetic
    fra_dp #(
        .ENTRIES     (ENTRIES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .op             (op),
        .request_size   (request_size),
        .request_offset (request_offset),
        .out_ready      (out_ready),
        .stat           (stat),
        .out_valid      (out_valid),
        .status         (status),
        .granted_offset (granted_offset),
        .free_total     (free_total)
    );

    // the block drops in_ready in the cycle after it accepts an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready still high after an item was accepted");

    // only a successful allocate carries an offset
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != fra_pkg::ST_OK)) |-> (granted_offset == '0))
        else $error("nonzero offset on a failed request");

    // a region write starts a clearing pass
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("block ready right after a region write");

endmodule

`default_nettype wire

// File: src/fra_ctrl.sv
`default_nettype none

module fra_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             cfg_we,
    input  wire fra_pkg::dp_stat_t stat,
    output fra_pkg::cmd_t         cmd,
    output logic                  in_ready
);

    fra_pkg::state_t state_reg;
    fra_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fra_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fra_pkg::S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = fra_pkg::S_IDLE;
                end
            end
            fra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.zero_free)
                    begin
                        state_next = fra_pkg::S_DONE;
                    end
                    else if (stat.is_free)
                    begin
                        state_next = fra_pkg::S_F_FETCH;
                    end
                    else
                    begin
                        state_next = fra_pkg::S_A_FETCH;
                    end
                end
            end
            fra_pkg::S_A_FETCH:
            begin
                state_next = stat.walk_end ? fra_pkg::S_DONE : fra_pkg::S_A_CHECK;
            end
            fra_pkg::S_A_CHECK:
            begin
                state_next = stat.a_hit ? fra_pkg::S_DONE : fra_pkg::S_A_FETCH;
            end
            fra_pkg::S_F_FETCH:
            begin
                state_next = stat.walk_end ? fra_pkg::S_SCAN : fra_pkg::S_F_CHECK;
            end
            fra_pkg::S_F_CHECK:
            begin
                if (stat.f_append)
                begin
                    state_next = fra_pkg::S_F_NX;
                end
                else if (stat.f_before)
                begin
                    state_next = fra_pkg::S_SCAN;
                end
                else
                begin
                    state_next = fra_pkg::S_F_FETCH;
                end
            end
            fra_pkg::S_F_NX:
            begin
                state_next = fra_pkg::S_F_MERGE;
            end
            fra_pkg::S_F_MERGE:
            begin
                state_next = fra_pkg::S_DONE;
            end
            fra_pkg::S_SCAN:
            begin
                if (stat.scan_found)
                begin
                    state_next = fra_pkg::S_INS_A;
                end
                else if (stat.scan_none)
                begin
                    state_next = fra_pkg::S_DONE;
                end
            end
            fra_pkg::S_INS_A:
            begin
                state_next = stat.ins_two ? fra_pkg::S_INS_B : fra_pkg::S_DONE;
            end
            fra_pkg::S_INS_B:
            begin
                state_next = fra_pkg::S_DONE;
            end
            fra_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = fra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fra_pkg::S_CLEAR;
            end
        endcase
        if (cfg_we)
        begin
            state_next = fra_pkg::S_CLEAR;
        end
    end

    // outputs
    always_comb
    begin
        cmd      = fra_pkg::CMD_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            fra_pkg::S_CLEAR:   cmd = fra_pkg::CMD_CLEAR;
            fra_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd      = in_valid ? fra_pkg::CMD_START : fra_pkg::CMD_NONE;
            end
            fra_pkg::S_A_FETCH: cmd = fra_pkg::CMD_A_FETCH;
            fra_pkg::S_A_CHECK: cmd = fra_pkg::CMD_A_CHECK;
            fra_pkg::S_F_FETCH: cmd = fra_pkg::CMD_F_FETCH;
            fra_pkg::S_F_CHECK: cmd = fra_pkg::CMD_F_CHECK;
            fra_pkg::S_F_NX:    cmd = fra_pkg::CMD_F_NX;
            fra_pkg::S_F_MERGE: cmd = fra_pkg::CMD_F_MERGE;
            fra_pkg::S_SCAN:    cmd = fra_pkg::CMD_SCAN;
            fra_pkg::S_INS_A:   cmd = fra_pkg::CMD_INS_A;
            fra_pkg::S_INS_B:   cmd = fra_pkg::CMD_INS_B;
            fra_pkg::S_DONE:    cmd = fra_pkg::CMD_DONE;
            default:            cmd = fra_pkg::CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/fra_dp.sv
`default_nettype none

module fra_dp #(
    parameter int ENTRIES     = 64,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fra_pkg::cmd_t cmd,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          op,
    input  wire logic [31:0]   request_size,
    input  wire logic [31:0]   request_offset,
    input  wire logic          out_ready,
    output fra_pkg::dp_stat_t  stat,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic [31:0]        granted_offset,
    output logic [31:0]        free_total
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = IW + 1;
    localparam int OB = OFFSET_BITS;
    localparam logic [LW-1:0] NO_ENTRY = LW'(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [63:0] RESET_EXT = 64'(fra_pkg::RESET_REGION);
    localparam logic [OB-1:0] RESET_SUM = RESET_EXT[OB-1:0];

    typedef struct packed {
        logic [OB-1:0] start;
        logic [OB-1:0] len;
        logic [LW-1:0] link;
    } rec_t;

    // range table and used flags
    rec_t rec_mem [ENTRIES];
    rec_t rec_q;
    logic used_mem [ENTRIES];
    logic used_q;

    logic          rec_we, rec_re, used_we, used_wdata, used_re;
    logic [IW-1:0] rec_waddr, rec_raddr, used_waddr, used_raddr;
    rec_t          rec_wdata;

    // widened inputs
    logic [63:0]   size_ext, off_ext, cfg_ext;
    logic [OB-1:0] size_w, off_w, cfg_w;

    // control registers
    logic [LW-1:0] cur_reg, cur_next, prev_reg, prev_next, steps_reg, steps_next;
    logic [LW-1:0] first_reg, first_next, rd_idx_reg, rd_idx_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next, n_reg, n_next, clr_idx_reg, clr_idx_next;
    logic          pend_reg, pend_next, tail_reg, tail_next, mprev_reg, mprev_next;
    logic          op_reg, op_next, out_valid_reg, out_valid_next;
    logic [1:0]    st_reg, st_next;
    logic [OB-1:0] sum_reg, sum_next;

    // payload registers
    logic [OB-1:0] size_reg, size_next, off_reg, off_next, grant_reg, grant_next;
    rec_t          cur_rec_reg, cur_rec_next, prev_rec_reg, prev_rec_next;
    logic [1:0]    ostat_reg, ostat_next;
    logic [31:0]   ogrant_reg, ogrant_next, osum_reg, osum_next;
    logic [63:0]   grant_ext, sum_ext;

    // compare and merge terms
    logic [IW-1:0] cur_idx, prev_idx;
    logic          walk_end, prev_valid, a_exact, a_bigger, f_append, f_before;
    logic [OB-1:0] f_end, m1_len, m1_end, ins_end, prev_end, m_len;
    logic          nx_valid, nx_merge, merge_next, merge_prev;
    logic [LW-1:0] m_link;
    logic          scan_found, scan_none, out_free;

    assign size_ext = 64'(request_size);
    assign off_ext  = 64'(request_offset);
    assign cfg_ext  = 64'(cfg_wdata);
    assign size_w   = size_ext[OB-1:0];
    assign off_w    = off_ext[OB-1:0];
    assign cfg_w    = cfg_ext[OB-1:0];

    assign cur_idx    = cur_reg[IW-1:0];
    assign prev_idx   = prev_reg[IW-1:0];
    assign walk_end   = (cur_reg >= NO_ENTRY) || (steps_reg == NO_ENTRY);
    assign prev_valid = prev_reg < NO_ENTRY;
    assign a_exact    = rec_q.len == size_reg;
    assign a_bigger   = rec_q.len > size_reg;
    assign f_end      = rec_q.start + rec_q.len;
    assign f_append   = f_end == off_reg;
    assign f_before   = rec_q.start > off_reg;

    assign nx_valid = cur_rec_reg.link < NO_ENTRY;
    assign m1_len   = cur_rec_reg.len + size_reg;
    assign m1_end   = cur_rec_reg.start + m1_len;
    assign nx_merge = nx_valid && (rec_q.start == m1_end);

    assign ins_end    = off_reg + size_reg;
    assign prev_end   = prev_rec_reg.start + prev_rec_reg.len;
    assign merge_next = !tail_reg && (ins_end == cur_rec_reg.start);
    assign merge_prev = !tail_reg && prev_valid && (prev_end == off_reg);
    assign m_len      = merge_next ? (size_reg + cur_rec_reg.len) : size_reg;
    assign m_link     = tail_reg ? NO_ENTRY : (merge_next ? cur_rec_reg.link : cur_reg);

    assign scan_found = pend_reg && !used_q;
    assign scan_none  = !scan_found && (rd_idx_reg == NO_ENTRY);
    assign out_free   = !out_valid_reg || out_ready;

    assign stat.walk_end   = walk_end;
    assign stat.a_hit      = a_exact || a_bigger;
    assign stat.f_append   = f_append;
    assign stat.f_before   = f_before;
    assign stat.scan_found = scan_found;
    assign stat.scan_none  = scan_none;
    assign stat.ins_two    = merge_prev || prev_valid;
    assign stat.clr_last   = clr_idx_reg == LAST_IDX;
    assign stat.out_free   = out_free;
    assign stat.zero_free  = op && (size_w == '0);
    assign stat.is_free    = op;

    always_comb
    begin
        rec_we        = 1'b0;
        rec_waddr     = cur_idx;
        rec_wdata     = cur_rec_reg;
        rec_re        = 1'b0;
        rec_raddr     = cur_idx;
        used_we       = 1'b0;
        used_waddr    = cur_idx;
        used_wdata    = 1'b0;
        used_re       = 1'b0;
        used_raddr    = rd_idx_reg[IW-1:0];
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        first_next    = first_reg;
        rd_idx_next   = rd_idx_reg;
        pend_idx_next = pend_idx_reg;
        n_next        = n_reg;
        clr_idx_next  = clr_idx_reg;
        pend_next     = pend_reg;
        tail_next     = tail_reg;
        mprev_next    = mprev_reg;
        op_next       = op_reg;
        st_next       = st_reg;
        sum_next      = sum_reg;
        size_next     = size_reg;
        off_next      = off_reg;
        grant_next    = grant_reg;
        cur_rec_next  = cur_rec_reg;
        prev_rec_next = prev_rec_reg;
        ostat_next    = ostat_reg;
        ogrant_next   = ogrant_reg;
        osum_next     = osum_reg;
        grant_ext     = 64'(grant_reg);
        sum_ext       = 64'(sum_reg);
        out_valid_next = out_valid_reg && !out_ready;

        case (cmd)
            fra_pkg::CMD_CLEAR:
            begin
                used_we      = 1'b1;
                used_waddr   = clr_idx_reg;
                used_wdata   = (clr_idx_reg == '0) && (first_reg == '0);
                rec_we       = clr_idx_reg == '0;
                rec_waddr    = '0;
                rec_wdata    = '{start: '0, len: sum_reg, link: NO_ENTRY};
                clr_idx_next = (clr_idx_reg == LAST_IDX) ? '0 : clr_idx_reg + 1'b1;
            end
            fra_pkg::CMD_START:
            begin
                op_next    = op;
                size_next  = size_w;
                off_next   = off_w;
                cur_next   = first_reg;
                prev_next  = NO_ENTRY;
                steps_next = '0;
                grant_next = '0;
                st_next    = (op && (size_w == '0)) ? fra_pkg::ST_ZERO : fra_pkg::ST_OK;
            end
            fra_pkg::CMD_A_FETCH:
            begin
                rec_re = !walk_end;
                if (walk_end)
                begin
                    st_next = fra_pkg::ST_NOFIT;
                end
            end
            fra_pkg::CMD_A_CHECK:
            begin
                cur_rec_next = rec_q;
                if (a_exact)
                begin
                    grant_next = rec_q.start;
                    if (prev_valid)
                    begin
                        rec_we    = 1'b1;
                        rec_waddr = prev_idx;
                        rec_wdata = '{start: prev_rec_reg.start, len: prev_rec_reg.len,
                                      link: rec_q.link};
                    end
                    else
                    begin
                        first_next = rec_q.link;
                    end
                    used_we    = 1'b1;
                    used_waddr = cur_idx;
                    used_wdata = 1'b0;
                    sum_next   = sum_reg - size_reg;
                end
                else if (a_bigger)
                begin
                    grant_next = rec_q.start;
                    rec_we     = 1'b1;
                    rec_waddr  = cur_idx;
                    rec_wdata  = '{start: rec_q.start + size_reg, len: rec_q.len - size_reg,
                                   link: rec_q.link};
                    sum_next   = sum_reg - size_reg;
                end
                else
                begin
                    prev_next     = cur_reg;
                    prev_rec_next = rec_q;
                    cur_next      = rec_q.link;
                    steps_next    = steps_reg + 1'b1;
                end
            end
            fra_pkg::CMD_F_FETCH:
            begin
                rec_re      = !walk_end;
                tail_next   = walk_end;
                rd_idx_next = '0;
                pend_next   = 1'b0;
            end
            fra_pkg::CMD_F_CHECK:
            begin
                cur_rec_next = rec_q;
                tail_next    = 1'b0;
                rd_idx_next  = '0;
                pend_next    = 1'b0;
                if (!f_append && !f_before)
                begin
                    prev_next     = cur_reg;
                    prev_rec_next = rec_q;
                    cur_next      = rec_q.link;
                    steps_next    = steps_reg + 1'b1;
                end
            end
            fra_pkg::CMD_F_NX:
            begin
                rec_re    = nx_valid;
                rec_raddr = cur_rec_reg.link[IW-1:0];
            end
            fra_pkg::CMD_F_MERGE:
            begin
                rec_we    = 1'b1;
                rec_waddr = cur_idx;
                rec_wdata = '{start: cur_rec_reg.start,
                              len: nx_merge ? (m1_len + rec_q.len) : m1_len,
                              link: nx_merge ? rec_q.link : cur_rec_reg.link};
                if (nx_merge)
                begin
                    used_we    = 1'b1;
                    used_waddr = cur_rec_reg.link[IW-1:0];
                    used_wdata = 1'b0;
                end
                sum_next = sum_reg + size_reg;
            end
            fra_pkg::CMD_SCAN:
            begin
                // one used flag read per cycle, checked the cycle after
                if (scan_found)
                begin
                    n_next     = pend_idx_reg;
                    used_we    = 1'b1;
                    used_waddr = pend_idx_reg;
                    used_wdata = 1'b1;
                    pend_next  = 1'b0;
                end
                else if (rd_idx_reg < NO_ENTRY)
                begin
                    used_re       = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IW-1:0];
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end
                else
                begin
                    st_next   = fra_pkg::ST_FULL;
                    pend_next = 1'b0;
                end
            end
            fra_pkg::CMD_INS_A:
            begin
                rec_we = 1'b1;
                if (merge_prev)
                begin
                    rec_waddr = prev_idx;
                    rec_wdata = '{start: prev_rec_reg.start, len: prev_rec_reg.len + m_len,
                                  link: m_link};
                end
                else
                begin
                    rec_waddr = n_reg;
                    rec_wdata = '{start: off_reg, len: m_len, link: m_link};
                    if (!prev_valid)
                    begin
                        first_next = {1'b0, n_reg};
                    end
                end
                if (merge_next)
                begin
                    used_we    = 1'b1;
                    used_waddr = cur_idx;
                    used_wdata = 1'b0;
                end
                mprev_next = merge_prev;
                sum_next   = sum_reg + size_reg;
            end
            fra_pkg::CMD_INS_B:
            begin
                if (mprev_reg)
                begin
                    used_we    = 1'b1;
                    used_waddr = n_reg;
                    used_wdata = 1'b0;
                end
                else
                begin
                    rec_we    = 1'b1;
                    rec_waddr = prev_idx;
                    rec_wdata = '{start: prev_rec_reg.start, len: prev_rec_reg.len,
                                  link: {1'b0, n_reg}};
                end
            end
            fra_pkg::CMD_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ostat_next     = st_reg;
                    ogrant_next    = grant_ext[31:0];
                    osum_next      = sum_ext[31:0];
                end
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase

        // region write restarts the table
        if (cfg_we)
        begin
            sum_next     = cfg_w;
            first_next   = (cfg_w == '0) ? NO_ENTRY : '0;
            clr_idx_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (rec_re)
        begin
            rec_q <= rec_mem[rec_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        if (used_re)
        begin
            used_q <= used_mem[used_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= NO_ENTRY;
            prev_reg      <= NO_ENTRY;
            steps_reg     <= '0;
            first_reg     <= (RESET_SUM == '0) ? NO_ENTRY : '0;
            rd_idx_reg    <= '0;
            pend_idx_reg  <= '0;
            n_reg         <= '0;
            clr_idx_reg   <= '0;
            pend_reg      <= 1'b0;
            tail_reg      <= 1'b0;
            mprev_reg     <= 1'b0;
            op_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= fra_pkg::ST_OK;
            sum_reg       <= RESET_SUM;
        end
        else
        begin
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            steps_reg     <= steps_next;
            first_reg     <= first_next;
            rd_idx_reg    <= rd_idx_next;
            pend_idx_reg  <= pend_idx_next;
            n_reg         <= n_next;
            clr_idx_reg   <= clr_idx_next;
            pend_reg      <= pend_next;
            tail_reg      <= tail_next;
            mprev_reg     <= mprev_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg     <= size_next;
        off_reg      <= off_next;
        grant_reg    <= grant_next;
        cur_rec_reg  <= cur_rec_next;
        prev_rec_reg <= prev_rec_next;
        ostat_reg    <= ostat_next;
        ogrant_reg   <= ogrant_next;
        osum_reg     <= osum_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = ostat_reg;
    assign granted_offset = ogrant_reg;
    assign free_total     = osum_reg;

endmodule

`default_nettype wire
